FILE: sv/aes128_pkg.sv
// Package: payload types, S-box and round helper functions for the AES-128 encryptor.
package aes128_pkg;

  typedef struct packed {
    logic [63:0] plain_hi;
    logic [63:0] plain_lo;
  } in_beat_t;

  typedef struct packed {
    logic [63:0] cipher_hi;
    logic [63:0] cipher_lo;
  } out_beat_t;

  localparam int unsigned NumRounds = 10;
  localparam logic [0:0] RegKeyHi = 1'b0;
  localparam logic [0:0] RegKeyLo = 1'b1;

  localparam logic [7:0] SboxTab [256] = '{
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
  };

  // Byte i of a 128-bit block sits at bits 127-8i : 120-8i.
  function automatic logic [7:0] get_byte(logic [127:0] v, int unsigned i);
    return v[127 - 8*i -: 8];
  endfunction

  function automatic logic [7:0] gf_dbl(logic [7:0] b);
    return {b[6:0], 1'b0} ^ (b[7] ? 8'h1b : 8'h00);
  endfunction

  // Round constant for round r (1..10).
  function automatic logic [7:0] rcon(int unsigned r);
    logic [7:0] c;
    c = 8'h01;
    for (int unsigned i = 1; i < r; i++) c = gf_dbl(c);
    return c;
  endfunction

  function automatic logic [127:0] next_key(logic [127:0] k, logic [7:0] rc);
    logic [7:0] b [16];
    for (int unsigned i = 0; i < 16; i++) b[i] = get_byte(k, i);
    b[0] = b[0] ^ SboxTab[b[13]] ^ rc;
    b[1] = b[1] ^ SboxTab[b[14]];
    b[2] = b[2] ^ SboxTab[b[15]];
    b[3] = b[3] ^ SboxTab[b[12]];
    for (int unsigned i = 4; i < 16; i++) b[i] = b[i] ^ b[i-4];
    return {b[0], b[1], b[2], b[3], b[4], b[5], b[6], b[7],
            b[8], b[9], b[10], b[11], b[12], b[13], b[14], b[15]};
  endfunction

  // SubBytes, ShiftRows, optional MixColumns, AddRoundKey.
  function automatic logic [127:0] enc_round(logic [127:0] s, logic [127:0] k,
                                              logic mix);
    logic [7:0] t [16];
    logic [7:0] a0, a1, a2, a3, al;
    logic [127:0] r;
    for (int unsigned c = 0; c < 4; c++)
      for (int unsigned w = 0; w < 4; w++)
        t[4*c+w] = SboxTab[get_byte(s, 4*((c+w) % 4) + w)];
    if (mix) begin
      for (int unsigned c = 0; c < 4; c++) begin
        a0 = t[4*c]; a1 = t[4*c+1]; a2 = t[4*c+2]; a3 = t[4*c+3];
        al = a0 ^ a1 ^ a2 ^ a3;
        t[4*c]   = a0 ^ al ^ gf_dbl(a0 ^ a1);
        t[4*c+1] = a1 ^ al ^ gf_dbl(a1 ^ a2);
        t[4*c+2] = a2 ^ al ^ gf_dbl(a2 ^ a3);
        t[4*c+3] = a3 ^ al ^ gf_dbl(a3 ^ a0);
      end
    end
    for (int unsigned i = 0; i < 16; i++) r[127 - 8*i -: 8] = t[i];
    return r ^ k;
  endfunction

endpackage

FILE: sv/aes128_round.sv
// One pipelined cipher round with its on-the-fly key step.
module aes128_round (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         adv_i,
  input  logic         valid_i,
  input  logic [127:0] state_i,
  input  logic [127:0] key_i,
  input  logic [7:0]   rcon_i,
  input  logic         mix_i,
  output logic         valid_o,
  output logic [127:0] state_o,
  output logic [127:0] key_o
);
  logic [127:0] key_d;
  logic         valid_q;
  logic [127:0] state_q, key_q;

  assign key_d = aes128_pkg::next_key(key_i, rcon_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (adv_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      state_q <= aes128_pkg::enc_round(state_i, key_d, mix_i);
      key_q   <= key_d;
    end
  end

  assign valid_o = valid_q;
  assign state_o = state_q;
  assign key_o   = key_q;
endmodule

FILE: sv/aes128_block_encrypt.sv
// Top level: AES-128 block encryptor with an eleven-stage pipeline.
//
// Input channel: in_valid / in_stall carry one plaintext beat
// (plain_hi, plain_lo). A beat is taken on an edge with valid high and
// stall low. Output channel: out_valid / out_stall carry the
// ciphertext beat in the same way.
// Key: written over the config channel (index 0 key_hi, index 1 key_lo,
// other indexes dropped); ready is always high. Write the key only while
// the pipeline is empty.
// Stages: one for the initial AddRoundKey, then one per round, each
// holding one S-box layer (with MixColumns in all but the last round)
// plus the matching key expansion step.
// Throughput: one beat per cycle while the receiver does not stall.
// Stall: the whole pipe advances together whenever the output register is
// empty or being taken; bubbles are squeezed out, so stall reaches the
// input only when every stage holds a beat and the receiver stalls.
// Reset clears all valid bits and the key registers to zero.
module aes128_block_encrypt (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  aes128_pkg::in_beat_t  in_data_i,
  output logic                  out_valid,
  input  logic                  out_stall,
  output aes128_pkg::out_beat_t out_data_o,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [0:0]            cfg_index_i,
  input  logic [63:0]           cfg_data_i
);
  localparam int unsigned N = aes128_pkg::NumRounds;

  logic [63:0] key_hi_q, key_lo_q;
  logic        vld [N+1];
  logic [127:0] st [N+1];
  logic [127:0] ky [N+1];
  logic        adv [N+1];
  logic        vld0_q;
  logic [127:0] st0_q, ky0_q;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_hi_q <= '0;
      key_lo_q <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_index_i)
        aes128_pkg::RegKeyHi: key_hi_q <= cfg_data_i;
        aes128_pkg::RegKeyLo: key_lo_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Stage k advances when it is empty or the next stage advances.
  assign adv[N] = !vld[N] || !out_stall;
  for (genvar g = N - 1; g >= 0; g--) begin : g_adv
    assign adv[g] = !vld[g] || adv[g+1];
  end
  assign in_stall = !adv[0];

  // Initial AddRoundKey stage.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld0_q <= 1'b0;
    end else if (adv[0]) begin
      vld0_q <= in_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv[0]) begin
      st0_q <= {in_data_i.plain_hi, in_data_i.plain_lo} ^ {key_hi_q, key_lo_q};
      ky0_q <= {key_hi_q, key_lo_q};
    end
  end

  assign vld[0] = vld0_q;
  assign st[0]  = st0_q;
  assign ky[0]  = ky0_q;

  for (genvar r = 1; r <= N; r++) begin : g_rnd
    aes128_round u_round (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .adv_i  (adv[r]),
      .valid_i(vld[r-1]),
      .state_i(st[r-1]),
      .key_i  (ky[r-1]),
      .rcon_i (aes128_pkg::rcon(r)),
      .mix_i  (r != N),
      .valid_o(vld[r]),
      .state_o(st[r]),
      .key_o  (ky[r])
    );
  end

  assign out_valid  = vld[N];
  assign out_data_o = st[N];

  // A stalled output beat holds its data.
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && out_stall |=> out_valid && $stable(out_data_o))
    else $error("output beat changed under stall");
  // Input is stalled only when the pipe is full and the output is stalled.
  a_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall |-> out_valid && out_stall && vld[0])
    else $error("spurious input stall");
  // An accepted beat enters the first stage.
  a_enter: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid && !in_stall |=> vld[0])
    else $error("accepted beat lost");
endmodule

FILE: tb/sv/aes128_block_encrypt_test.sv
// Testbench for the AES-128 block encryptor: self-checking against a local cipher model.
module aes128_block_encrypt_test;

  // Substitution table, held locally so the expected ciphertext is built independently.
  localparam logic [7:0] Sub [256] = '{
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
  };

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  aes128_pkg::in_beat_t  in_data_i = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  aes128_pkg::out_beat_t out_data_o;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [0:0]  cfg_index_i = aes128_pkg::RegKeyHi;
  logic [63:0] cfg_data_i = '0;

  // Local copy of the key registers, updated as the writes land.
  logic [63:0] key_hi_q = '0;
  logic [63:0] key_lo_q = '0;

  aes128_pkg::out_beat_t cipher_queue [$];
  int          mismatches = 0;
  int          checked = 0;
  int          sent = 0;
  bit          idle_on = 1'b1;   // random gaps on both sides while set
  bit          hold_off = 1'b0;  // long receiver stall for the pressure test

  aes128_block_encrypt dut (.*);

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  function automatic logic [7:0] xtime(logic [7:0] b);
    return {b[6:0], 1'b0} ^ (b[7] ? 8'h1b : 8'h00);
  endfunction

  // Encrypt one block under the current local key, byte 0 in the top bits.
  function automatic aes128_pkg::out_beat_t encrypt_block(aes128_pkg::in_beat_t p,
                                                          logic [127:0] key);
    logic [7:0] st [16];
    logic [7:0] rk [16];
    logic [7:0] tmp [16];
    logic [7:0] rc;
    logic [7:0] a0, a1, a2, a3, sum;
    logic [127:0] blk;
    aes128_pkg::out_beat_t res;
    blk = {p.plain_hi, p.plain_lo};
    rc = 8'h01;
    for (int i = 0; i < 16; i++) begin
      rk[i] = key[127 - 8*i -: 8];
      st[i] = blk[127 - 8*i -: 8] ^ rk[i];
    end
    for (int r = 1; r <= 10; r++) begin
      // advance the round key
      rk[0] = rk[0] ^ Sub[rk[13]] ^ rc;
      rk[1] = rk[1] ^ Sub[rk[14]];
      rk[2] = rk[2] ^ Sub[rk[15]];
      rk[3] = rk[3] ^ Sub[rk[12]];
      for (int i = 4; i < 16; i++) rk[i] = rk[i] ^ rk[i-4];
      rc = xtime(rc);
      // substitute and shift rows
      for (int c = 0; c < 4; c++)
        for (int w = 0; w < 4; w++) tmp[4*c+w] = Sub[st[4*((c+w)%4)+w]];
      if (r != 10) begin
        for (int c = 0; c < 4; c++) begin
          a0 = tmp[4*c]; a1 = tmp[4*c+1]; a2 = tmp[4*c+2]; a3 = tmp[4*c+3];
          sum = a0 ^ a1 ^ a2 ^ a3;
          tmp[4*c]   = a0 ^ sum ^ xtime(a0 ^ a1);
          tmp[4*c+1] = a1 ^ sum ^ xtime(a1 ^ a2);
          tmp[4*c+2] = a2 ^ sum ^ xtime(a2 ^ a3);
          tmp[4*c+3] = a3 ^ sum ^ xtime(a3 ^ a0);
        end
      end
      for (int i = 0; i < 16; i++) st[i] = tmp[i] ^ rk[i];
    end
    for (int i = 0; i < 16; i++) blk[127 - 8*i -: 8] = st[i];
    res.cipher_hi = blk[127:64];
    res.cipher_lo = blk[63:0];
    return res;
  endfunction

  // Write one key register; only called with the pipe drained.
  task automatic write_key(logic [0:0] idx, logic [63:0] val);
    @(posedge clk_i);
    cfg_valid <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    do @(posedge clk_i); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == aes128_pkg::RegKeyHi) key_hi_q = val;
    else key_lo_q = val;
  endtask

  // Send one plaintext beat, with an optional random gap first.
  task automatic send_block(logic [63:0] hi, logic [63:0] lo);
    aes128_pkg::in_beat_t b;
    int gap;
    b.plain_hi = hi;
    b.plain_lo = lo;
    if (idle_on && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 16);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid <= 1'b1;
    in_data_i <= b;
    cipher_queue.push_back(encrypt_block(b, {key_hi_q, key_lo_q}));
    sent++;
    do @(posedge clk_i); while (in_stall);
  endtask

  task automatic end_burst();
    in_valid <= 1'b0;
  endtask

  // Wait for the pipe to drain, then cover the pipeline latency.
  task automatic drain();
    end_burst();
    while (cipher_queue.size() != 0) @(posedge clk_i);
    repeat (14) @(posedge clk_i);
  endtask

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  // Pick a block: mostly random, sometimes extreme or single-bit patterns.
  function automatic logic [63:0] pick64();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return '1;
      2: return 64'd1 << $urandom_range(0, 63);
      3: return ~(64'd1 << $urandom_range(0, 63));
      default: return rand64();
    endcase
  endfunction

  // Receiver: random stall bursts, plus the long hold-off on request.
  initial begin
    int n;
    @(posedge rst_ni);
    forever begin
      if (hold_off) begin
        out_stall <= 1'b1;
        @(posedge clk_i);
      end else if (idle_on && $urandom_range(0, 4) == 0) begin
        n = $urandom_range(1, 16);
        out_stall <= 1'b1;
        repeat (n) @(posedge clk_i);
        out_stall <= 1'b0;
        repeat ($urandom_range(1, 20)) @(posedge clk_i);
      end else begin
        out_stall <= 1'b0;
        @(posedge clk_i);
      end
    end
  end

  // Compare each taken output beat with the oldest expected ciphertext.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid && !out_stall) begin
      if (cipher_queue.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected output beat %h_%h", out_data_o.cipher_hi, out_data_o.cipher_lo);
      end else begin
        if (out_data_o !== cipher_queue[0]) begin
          mismatches++;
          if (mismatches <= 10)
            $display("beat %0d: expected %h_%h got %h_%h", checked,
                     cipher_queue[0].cipher_hi, cipher_queue[0].cipher_lo,
                     out_data_o.cipher_hi, out_data_o.cipher_lo);
        end
        void'(cipher_queue.pop_front());
        checked++;
      end
    end
  end

  // Reset-value key, the standard vector and an all-ones key, each with extremes of the block fields.
  task automatic test_directed();
    send_block('0, '0);
    send_block('1, '1);
    send_block(64'h8000_0000_0000_0000, 64'h1);
    drain();
    write_key(aes128_pkg::RegKeyHi, 64'h0001_0203_0405_0607);
    write_key(aes128_pkg::RegKeyLo, 64'h0809_0a0b_0c0d_0e0f);
    send_block(64'h0011_2233_4455_6677, 64'h8899_aabb_ccdd_eeff);
    send_block('0, '1);
    send_block('1, '0);
    drain();
    write_key(aes128_pkg::RegKeyHi, '1);
    write_key(aes128_pkg::RegKeyLo, '1);
    send_block('0, '0);
    send_block('1, '1);
    send_block(64'h5555_5555_5555_5555, 64'haaaa_aaaa_aaaa_aaaa);
    drain();
  endtask

  // Random blocks under several random keys.
  task automatic test_random(int phases, int per_phase);
    for (int p = 0; p < phases; p++) begin
      write_key(aes128_pkg::RegKeyHi, pick64());
      write_key(aes128_pkg::RegKeyLo, pick64());
      for (int i = 0; i < per_phase; i++) send_block(pick64(), pick64());
      drain();
    end
  endtask

  // Hold the receiver off long enough for the pipe to fill and stall input.
  task automatic test_backpressure();
    hold_off = 1'b1;
    fork
      begin
        for (int i = 0; i < 30; i++) send_block(rand64(), rand64());
        end_burst();
      end
      begin
        repeat (60) @(posedge clk_i);
        hold_off = 1'b0;
      end
    join
    drain();
  endtask

  initial begin
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    test_directed();
    test_random(8, 80);
    test_backpressure();
    idle_on = 1'b0;
    test_random(3, 60);
    $display("ran %0d blocks over several keys, extremes and back-pressure; %0d checked",
             sent, checked);
    if (mismatches == 0 && cipher_queue.size() == 0)
      $display("aes128_block_encrypt: match");
    else
      $display("aes128_block_encrypt: mismatch");
    $finish;
  end

  // Timeout guard.
  initial begin
    #4000000;
    $display("aes128_block_encrypt: mismatch");
    $finish;
  end

endmodule
